>>> sv/radix_digit_calculator_defines.svh
// Assertion macros used by the radix digit calculator top module.
// Depends on nothing; included by files that carry assertions.
`ifndef RADIX_DIGIT_CALCULATOR_DEFINES_SVH
`define RADIX_DIGIT_CALCULATOR_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define RDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define RDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/rdc_pkg.sv
// Shared types and constants of the radix digit calculator.
// Depends on nothing.
`timescale 1ns / 1ps
package rdc_pkg;
    localparam logic [7:0] OP_ADD = 8'd43;
    localparam logic [7:0] OP_SUB = 8'd45;
    localparam logic [7:0] OP_MUL = 8'd42;
    localparam logic [7:0] OP_DIV = 8'd47;
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_OP  = 3'd1;
    localparam logic [2:0] ST_BAD_BAS = 3'd2;
    localparam logic [2:0] ST_BAD_DIG = 3'd3;
    localparam logic [2:0] ST_DIV_0   = 3'd4;
    localparam int MAG_W = 54;
    // Request and reply of the shared divider.
    typedef struct packed {
        logic            start;
        logic [MAG_W-1:0] num;
        logic [MAG_W-1:0] den;
    } t_div_req;
    typedef struct packed {
        logic            done;
        logic [MAG_W-1:0] quo;
        logic [MAG_W-1:0] rem;
    } t_div_rsp;
endpackage

>>> sv/rdc_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all divides.
// Depends on rdc_pkg.
`timescale 1ns / 1ps
module rdc_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdc_pkg::t_div_req i_req,
    output rdc_pkg::t_div_rsp o_rsp
);
    localparam int W = rdc_pkg::MAG_W;
    logic [W-1:0] r_quo, r_den;
    logic [W:0]   r_rem;
    logic [5:0]   r_cnt;
    logic         r_busy, r_done;
    logic [W:0]   w_sh;
    logic [W:0]   w_df;

    assign w_sh = {r_rem[W-1:0], r_quo[W-1]};
    assign w_df = w_sh - {1'b0, r_den};

    // Shift one numerator bit in and subtract when it fits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= 6'(W - 1);
            end else if (r_busy) begin
                if (!w_df[W]) begin
                    r_rem <= w_df;
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[W-1:0];
endmodule

>>> sv/radix_digit_calculator.sv
// Radix digit calculator: operand checks, conversion, one operation, digit output.
// Steps: a check, conversion of OPERAND_DIGITS operand digits, the operation, then a
// divider pass for a divide and one shared divider pass per result digit.
// Handshake: one item at a time, ready only in IDLE with the output drained; each
// result digit passes through S_EMIT, then S_ERR, which loads the output register.
// Reset: synchronous active-low i_rst_n clears the sequencer and output valid.
`timescale 1ns / 1ps
`include "radix_digit_calculator_defines.svh"
module radix_digit_calculator #(
    parameter int OPERAND_DIGITS = 8,
    parameter int RESULT_DIGITS  = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[7:0], in_base[11:8], out_base[15:12], operand_a[47:16],
    // operand_b[79:48]
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], value_a[29:3], value_b[56:30], result_value[111:57],
    // negative[112], digit[116:113], zero fill up to 119
    output logic [119:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    localparam int W  = rdc_pkg::MAG_W;
    localparam int DW = $clog2(OPERAND_DIGITS + 1);
    localparam int RW = $clog2(RESULT_DIGITS + 1);
    localparam int AW = $clog2(RESULT_DIGITS);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_CONV, S_CALC, S_QWAIT, S_DSTART, S_DWAIT, S_EMIT, S_ERR
    } t_state;

    t_state       r_state;
    logic [7:0]   r_op;
    logic [3:0]   r_ib, r_ob;
    logic [31:0]  r_a, r_b;
    logic [DW-1:0] r_k;
    logic [26:0]  r_va, r_vb;
    logic [W-1:0] r_mag;
    logic [54:0]  r_rv;
    logic         r_neg;
    logic [2:0]   r_st;
    logic [RW-1:0] r_n;
    logic [AW-1:0] r_rd;
    logic         r_ovalid, r_olast;
    logic [3:0]   r_odig;
    logic [3:0]   r_mem [RESULT_DIGITS];
    logic [3:0]   r_memq;
    rdc_pkg::t_div_req w_req;
    rdc_pkg::t_div_rsp w_rsp;
    logic [3:0]   w_na, w_nb;
    logic         w_bad;
    logic [31:0]  w_sa, w_sb;

    rdc_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // Nibble under the digit pointer; nibbles past bit 31 read as zero.
    assign w_sa = r_a >> {r_k - DW'(1), 2'b00};
    assign w_sb = r_b >> {r_k - DW'(1), 2'b00};
    assign w_na = ({{(32-DW){1'b0}}, r_k} > 32'd8) ? 4'd0 : w_sa[3:0];
    assign w_nb = ({{(32-DW){1'b0}}, r_k} > 32'd8) ? 4'd0 : w_sb[3:0];
    assign w_bad = (w_na >= r_ib) || (w_nb >= r_ib);

    // Drive the shared divider from the sequencer.
    always_comb begin
        w_req.start = 1'b0;
        w_req.num   = r_mag;
        w_req.den   = {{(W-27){1'b0}}, r_vb};
        if (r_state == S_CALC && r_op == rdc_pkg::OP_DIV && r_vb != '0) begin
            w_req.start = 1'b1;
            w_req.num   = W'(r_va);
        end else if (r_state == S_DSTART) begin
            w_req.start = 1'b1;
            w_req.den   = {{(W-4){1'b0}}, r_ob};
        end
    end

    // Digit buffer, written during the result digit passes, read registered.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DWAIT && w_rsp.done) begin
            r_mem[r_n[AW-1:0]] <= w_rsp.rem[3:0];
        end
        r_memq <= r_mem[r_rd];
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_ovalid) begin
                        // Hold the last item until the receiver takes it.
                        if (m_axis_tready) r_ovalid <= 1'b0;
                    end else if (s_axis_tvalid) begin
                        r_op <= s_axis_tdata[7:0];
                        r_ib <= s_axis_tdata[11:8];
                        r_ob <= s_axis_tdata[15:12];
                        r_a  <= s_axis_tdata[47:16];
                        r_b  <= s_axis_tdata[79:48];
                        r_va <= '0;
                        r_vb <= '0;
                        r_k  <= DW'(OPERAND_DIGITS);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_rv <= '0; r_neg <= 1'b0;
                    if (r_op != rdc_pkg::OP_ADD && r_op != rdc_pkg::OP_SUB &&
                        r_op != rdc_pkg::OP_MUL && r_op != rdc_pkg::OP_DIV) begin
                        r_st <= rdc_pkg::ST_BAD_OP; r_state <= S_ERR;
                    end else if (r_ib < 4'd2 || r_ib > 4'd10 ||
                                 r_ob < 4'd2 || r_ob > 4'd10) begin
                        r_st <= rdc_pkg::ST_BAD_BAS; r_state <= S_ERR;
                    end else begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (w_bad) begin
                        r_st <= rdc_pkg::ST_BAD_DIG; r_va <= '0; r_vb <= '0;
                        r_state <= S_ERR;
                    end else begin
                        r_va <= 27'(r_va * r_ib + w_na);
                        r_vb <= 27'(r_vb * r_ib + w_nb);
                        r_k  <= r_k - DW'(1);
                        if (r_k == DW'(1)) r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_st <= rdc_pkg::ST_OK;
                    r_n  <= '0;
                    priority if (r_op == rdc_pkg::OP_ADD) begin
                        r_mag <= W'(r_va) + W'(r_vb);
                        r_rv  <= 55'(r_va) + 55'(r_vb);
                        r_state <= S_DSTART;
                    end else if (r_op == rdc_pkg::OP_SUB) begin
                        r_mag <= (r_va >= r_vb) ? W'(r_va - r_vb) : W'(r_vb - r_va);
                        r_neg <= r_va < r_vb;
                        r_rv  <= 55'(r_va) - 55'(r_vb);
                        r_state <= S_DSTART;
                    end else if (r_op == rdc_pkg::OP_MUL) begin
                        r_mag <= W'(r_va * r_vb);
                        r_rv  <= 55'(r_va * r_vb);
                        r_state <= S_DSTART;
                    end else if (r_vb == '0) begin
                        r_st <= rdc_pkg::ST_DIV_0;
                        r_state <= S_ERR;
                    end else begin
                        r_mag <= W'(r_va);
                        r_state <= S_QWAIT;
                    end
                end
                S_QWAIT: if (w_rsp.done) begin
                    r_mag <= w_rsp.quo;
                    r_rv  <= 55'(w_rsp.quo);
                    r_state <= S_DSTART;
                end
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: if (w_rsp.done) begin
                    r_mag <= w_rsp.quo;
                    r_n   <= r_n + RW'(1);
                    if (w_rsp.quo == '0 || r_n == RW'(RESULT_DIGITS - 1)) begin
                        r_rd <= r_n[AW-1:0];
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_DSTART;
                    end
                end
                S_EMIT: if (!r_ovalid || m_axis_tready) begin
                    // Let the registered buffer read catch up with the pointer before S_ERR uses it.
                    r_ovalid <= 1'b0;
                    r_state  <= S_ERR;
                end
                S_ERR: if (!r_ovalid || m_axis_tready) begin
                    r_ovalid <= 1'b1;
                    if (r_st == rdc_pkg::ST_OK) begin
                        r_odig  <= r_memq;
                        r_olast <= (r_rd == '0);
                        if (r_rd == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rd <= r_rd - AW'(1);
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_odig  <= '0;
                        r_olast <= 1'b1;
                        if (r_st != rdc_pkg::ST_DIV_0) begin
                            r_va <= '0; r_vb <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {3'd0, r_odig, r_neg, r_rv, r_vb, r_va, r_st};

    `RDC_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready, "ready while busy")
    `RDC_ASSERT_IMP(a_err_zero_dig, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[2:0] != rdc_pkg::ST_OK, m_axis_tlast && m_axis_tdata[116:113] == 4'd0, "error item not single")
    `RDC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output dropped")
endmodule
